// ----- src/gdc_pkg.sv -----
// Shared types, codes, constants and calendar tables for the date calculator.
// Used by the channel interfaces, the sequencer core and the top level.
package gdc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int CODE_W  = 2;
  localparam int OFF_W   = 23;
  localparam int ACC_W   = 24;
  localparam int QY_W    = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;

  localparam logic [CODE_W-1:0] STAT_OK      = 2'd0;
  localparam logic [CODE_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [CODE_W-1:0] STAT_RANGE   = 2'd2;

  localparam logic [CODE_W-1:0] ORD_EQUAL    = 2'd0;
  localparam logic [CODE_W-1:0] ORD_LATER    = 2'd1;
  localparam logic [CODE_W-1:0] ORD_EARLIER  = 2'd2;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] NUM_MONTHS = 4'd12;
  // day number of 9999-12-31 counted from 0001-01-01
  localparam logic [ACC_W-1:0]   LAST_DAY  = 24'd3652058;

  // year / 100 as (year * RECIP) >> RECIP_SHIFT, exact for 14-bit years
  localparam logic [12:0] RECIP       = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  HUNDRED     = 7'd100;
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;

  // 400-, 100-, 4- and 1-year blocks of the day number split
  localparam logic [17:0] DIV_BLOCK [4] = '{18'd146097, 18'd36524, 18'd1461, 18'd365};
  localparam logic [8:0]  DIV_YEARS [4] = '{9'd400, 9'd100, 9'd4, 9'd1};
  localparam logic [2:0]  DIV_TOP   [4] = '{3'd4, 3'd1, 3'd4, 3'd1};

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic signed [OFF_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic [CODE_W-1:0]       status;
    logic [CODE_W-1:0]       order;
    logic signed [OFF_W-1:0] difference;
  } result_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ----- src/gdc_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Field widths come from gdc_pkg.
interface gdc_req_if;
  logic                               valid;
  logic                               ready;
  logic [gdc_pkg::FUNC_W-1:0]         func;
  logic [gdc_pkg::YEAR_W-1:0]         in_year;
  logic [gdc_pkg::MONTH_W-1:0]        in_month;
  logic [gdc_pkg::DAY_W-1:0]          in_day;
  logic signed [gdc_pkg::OFF_W-1:0]   offset;

  modport source(output valid, func, in_year, in_month, in_day, offset, input ready);
  modport sink(input valid, func, in_year, in_month, in_day, offset, output ready);
endinterface

interface gdc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [gdc_pkg::YEAR_W-1:0]         out_year;
  logic [gdc_pkg::MONTH_W-1:0]        out_month;
  logic [gdc_pkg::DAY_W-1:0]          out_day;
  logic [gdc_pkg::CODE_W-1:0]         status;
  logic [gdc_pkg::CODE_W-1:0]         order;
  logic signed [gdc_pkg::OFF_W-1:0]   difference;

  modport source(output valid, out_year, out_month, out_day, status, order, difference,
                 input ready);
  modport sink(input valid, out_year, out_month, out_day, status, order, difference,
               output ready);
endinterface

// ----- src/gdc_core.sv -----
// Sequencer and shared accumulator for date check, day numbers and day-number split.
// Holds the stored date. Depends on gdc_pkg.
module gdc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gdc_pkg::item_t  item,
  input  logic            res_free,
  output logic            idle,
  output logic            done,
  output gdc_pkg::result_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_YQ, S_YL, S_ACC, S_OFF, S_RNG, S_DIV, S_MON, S_FIN
  } state_t;

  state_t state;

  logic [gdc_pkg::FUNC_W-1:0]        func_r;
  logic [gdc_pkg::YEAR_W-1:0]        gy;
  logic [gdc_pkg::MONTH_W-1:0]       gm;
  logic [gdc_pkg::DAY_W-1:0]         gd;
  logic signed [gdc_pkg::OFF_W-1:0]  off_r;
  logic                              wcur;
  logic                              neg;
  logic signed [gdc_pkg::ACC_W-1:0]  acc;
  logic [gdc_pkg::QY_W-1:0]          qy;
  logic [gdc_pkg::QY_W-1:0]          qp;
  logic                              leap;
  logic [2:0]                        k;
  logic [1:0]                        phase;
  logic [gdc_pkg::YEAR_W-1:0]        yr;
  logic [1:0]                        q100;
  logic [4:0]                        q4;
  logic [1:0]                        q1;
  logic [gdc_pkg::MONTH_W-1:0]       mm;
  logic [gdc_pkg::CODE_W-1:0]        status_r;
  logic [gdc_pkg::YEAR_W-1:0]        cur_y;
  logic [gdc_pkg::MONTH_W-1:0]       cur_m;
  logic [gdc_pkg::DAY_W-1:0]         cur_d;

  logic [gdc_pkg::YEAR_W-1:0]        y_sel;
  logic [gdc_pkg::MONTH_W-1:0]       m_sel;
  logic [gdc_pkg::DAY_W-1:0]         d_sel;
  logic [26:0]                       prod;
  logic [gdc_pkg::QY_W-1:0]          qy_next;
  logic [14:0]                       hund;
  logic                              ry0;
  logic                              leap_c;
  logic [gdc_pkg::YEAR_W-1:0]        p;
  logic [gdc_pkg::ACC_W-1:0]         tmag;
  logic                              neg_term;
  logic [21:0]                       dconst;
  logic [gdc_pkg::YEAR_W-1:0]        ystep;
  logic                              leap_res;
  logic signed [gdc_pkg::ACC_W-1:0]  op;
  logic signed [gdc_pkg::ACC_W-1:0]  sum;
  logic                              bad_md;
  logic [gdc_pkg::CODE_W-1:0]        chk;
  logic                              compare_ok;

  assign y_sel = wcur ? cur_y : gy;
  assign m_sel = wcur ? cur_m : gm;
  assign d_sel = wcur ? cur_d : gd;

  assign prod    = 27'(y_sel) * 27'(gdc_pkg::RECIP);
  assign qy_next = prod[gdc_pkg::RECIP_SHIFT +: gdc_pkg::QY_W];
  assign hund    = 15'(qy) * 15'(gdc_pkg::HUNDRED);
  assign ry0     = (hund == {1'b0, y_sel});
  assign leap_c  = (y_sel[1:0] == 2'd0) && (!ry0 || qy[1:0] == 2'd0);
  assign p       = y_sel - 14'd1;

  always_comb begin
    case (k)
      3'd0:    tmag = 24'(p) * 24'(gdc_pkg::YEAR_DAYS);
      3'd1:    tmag = 24'(p[13:2]);
      3'd2:    tmag = 24'(qp);
      3'd3:    tmag = 24'(qp[7:2]);
      3'd4:    tmag = 24'(gdc_pkg::days_before_month(m_sel, leap)) + 24'(d_sel) - 24'd1;
      default: tmag = '0;
    endcase
  end

  assign neg_term = neg ^ (k == 3'd2);
  assign dconst   = {4'b0, gdc_pkg::DIV_BLOCK[phase]} << k;
  assign ystep    = 14'(gdc_pkg::DIV_YEARS[phase]) << k;
  assign leap_res = (q1 == 2'd3) && (q4 != 5'd24 || q100 == 2'd3);

  always_comb begin
    case (state)
      S_ACC:   op = neg_term ? -$signed(tmag) : $signed(tmag);
      S_OFF:   op = gdc_pkg::ACC_W'(off_r);
      S_DIV:   op = -$signed({2'b0, dconst});
      S_MON:   op = -$signed(24'(gdc_pkg::month_len(mm, leap_res)));
      default: op = '0;
    endcase
  end

  assign sum = acc + op;

  assign bad_md = (gm == 4'd0) || (gm > gdc_pkg::NUM_MONTHS) || (gd == 5'd0) ||
                  (gd > gdc_pkg::month_len(gm, leap_c));
  assign chk = bad_md ? gdc_pkg::STAT_INVALID :
               ((gy == 14'd0) || (gy > gdc_pkg::MAX_YEAR)) ? gdc_pkg::STAT_RANGE :
               gdc_pkg::STAT_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_y <= 14'd1;
      cur_m <= 4'd1;
      cur_d <= 5'd1;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            func_r   <= item.func;
            gy       <= item.year;
            gm       <= item.month;
            gd       <= item.day;
            off_r    <= item.offset;
            acc      <= '0;
            status_r <= gdc_pkg::STAT_OK;
            wcur     <= (item.func == gdc_pkg::FUNC_ADD);
            if (item.func == gdc_pkg::FUNC_LOAD || item.func == gdc_pkg::FUNC_ADD ||
                item.func == gdc_pkg::FUNC_COMPARE) begin
              state <= S_YQ;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_YQ: begin
          qy    <= qy_next;
          state <= S_YL;
        end
        S_YL: begin
          leap <= leap_c;
          qp   <= qy - gdc_pkg::QY_W'(ry0);
          k    <= 3'd0;
          if (wcur) begin
            neg   <= 1'b0;
            state <= S_ACC;
          end else begin
            status_r <= chk;
            neg      <= 1'b1;
            if (func_r == gdc_pkg::FUNC_LOAD) begin
              if (chk == gdc_pkg::STAT_OK) begin
                cur_y <= gy;
                cur_m <= gm;
                cur_d <= gd;
              end
              state <= S_FIN;
            end else if (chk == gdc_pkg::STAT_OK) begin
              state <= S_ACC;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_ACC: begin
          acc <= sum;
          k   <= k + 3'd1;
          if (k == 3'd4) begin
            if (!wcur) begin
              wcur  <= 1'b1;
              state <= S_YQ;
            end else if (func_r == gdc_pkg::FUNC_ADD) begin
              state <= S_OFF;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_OFF: begin
          acc   <= sum;
          state <= S_RNG;
        end
        S_RNG: begin
          yr    <= '0;
          q100  <= '0;
          q4    <= '0;
          q1    <= '0;
          phase <= 2'd0;
          k     <= gdc_pkg::DIV_TOP[0];
          if (acc[gdc_pkg::ACC_W-1] || $unsigned(acc) > gdc_pkg::LAST_DAY) begin
            status_r <= gdc_pkg::STAT_RANGE;
            state    <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!sum[gdc_pkg::ACC_W-1]) begin
            acc <= sum;
            yr  <= yr + ystep;
          end
          case (phase)
            2'd1:    q100 <= {q100[0], !sum[gdc_pkg::ACC_W-1]};
            2'd2:    q4   <= {q4[3:0], !sum[gdc_pkg::ACC_W-1]};
            2'd3:    q1   <= {q1[0], !sum[gdc_pkg::ACC_W-1]};
            default: ;
          endcase
          if (k == 3'd0) begin
            if (phase == 2'd3) begin
              mm    <= 4'd1;
              state <= S_MON;
            end else begin
              phase <= phase + 2'd1;
              k     <= gdc_pkg::DIV_TOP[phase + 2'd1];
            end
          end else begin
            k <= k - 3'd1;
          end
        end
        S_MON: begin
          if (mm < gdc_pkg::NUM_MONTHS && !sum[gdc_pkg::ACC_W-1]) begin
            acc <= sum;
            mm  <= mm + 4'd1;
          end else begin
            cur_y <= yr + 14'd1;
            cur_m <= mm;
            cur_d <= acc[gdc_pkg::DAY_W-1:0] + 5'd1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_FIN) && res_free;

  assign compare_ok = (func_r == gdc_pkg::FUNC_COMPARE) && (status_r == gdc_pkg::STAT_OK);

  always_comb begin
    res.year   = cur_y;
    res.month  = cur_m;
    res.day    = cur_d;
    res.status = status_r;
    if (!compare_ok) begin
      res.order      = gdc_pkg::ORD_EQUAL;
      res.difference = '0;
    end else begin
      res.difference = acc[gdc_pkg::OFF_W-1:0];
      if (acc[gdc_pkg::ACC_W-1]) begin
        res.order = gdc_pkg::ORD_EARLIER;
      end else if (acc != '0) begin
        res.order = gdc_pkg::ORD_LATER;
      end else begin
        res.order = gdc_pkg::ORD_EQUAL;
      end
    end
  end

  a_cur_month: assert property (@(posedge clk) disable iff (rst)
    cur_m >= 4'd1 && cur_m <= gdc_pkg::NUM_MONTHS)
    else $error("stored month out of range");

  a_cur_year: assert property (@(posedge clk) disable iff (rst)
    cur_y >= 14'd1 && cur_y <= gdc_pkg::MAX_YEAR)
    else $error("stored year out of range");

  a_month_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_MON |-> mm <= gdc_pkg::NUM_MONTHS && !acc[gdc_pkg::ACC_W-1])
    else $error("month walk left its bounds");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && idle |=> !idle)
    else $error("accepted word did not start a run");

endmodule

// ----- src/gregorian_date_calculator_top.sv -----
// Top level of the Gregorian date calculator: request and response channels,
// response register, and the sequencer core. Depends on gdc_pkg, gdc_if, gdc_core.
//
// Usage:
//   req carries one word per operation: func selects load (check and store a
//   date), add (move the stored date by a signed day offset) or compare
//   (order and signed day difference of the stored date against the given one).
//   rsp returns exactly one word per request with the stored date after the
//   operation, a status code, and for compare the order and difference.
// Timing:
//   One request is in work at a time; req.ready is high only while the core
//   is idle, and rises again in the same cycle as the response word appears.
//   An add whose moved date leaves the year range ends before the split; an
//   unused func goes straight to its response. The day-number sums, the 14-step
//   split of a day number into years and the month walk of up to 12 steps all
//   use one 24-bit accumulator.
// Reset:
//   rst is synchronous; the stored date becomes 0001-01-01 and rsp is empty.
// Stall:
//   rsp is registered. A new request is taken while a response waits; the core
//   then holds its finished result until rsp.ready frees the register.
module gregorian_date_calculator_top (
  input logic        clk,
  input logic        rst,
  gdc_req_if.sink    req,
  gdc_rsp_if.source  rsp
);

  gdc_pkg::item_t   item;
  gdc_pkg::result_t res;
  logic             idle;
  logic             done;
  logic             res_free;
  logic             start;

  assign item.func   = req.func;
  assign item.year   = req.in_year;
  assign item.month  = req.in_month;
  assign item.day    = req.in_day;
  assign item.offset = req.offset;

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign res_free  = !rsp.valid || rsp.ready;

  gdc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .res_free (res_free),
    .idle     (idle),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      if (done) begin
        rsp.valid      <= 1'b1;
        rsp.out_year   <= res.year;
        rsp.out_month  <= res.month;
        rsp.out_day    <= res.day;
        rsp.status     <= res.status;
        rsp.order      <= res.order;
        rsp.difference <= res.difference;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_calculator_top: directed and random
// load, add, compare and spare-func words with a class scoreboard that tracks
// the stored date. Depends on gdc_pkg, gdc_if and the top level of the block.
module tb;

  localparam logic [gdc_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int NUM_RANDOM = 900;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;

  class date_tracker;
    int unsigned cur_y;
    int unsigned cur_m;
    int unsigned cur_d;
    gdc_pkg::result_t expected_q[$];
    int unsigned errors;

    function new();
      cur_y = 1;
      cur_m = 1;
      cur_d = 1;
      errors = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
        2: return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    static function longint year_start(int unsigned y);
      longint p;
      p = longint'(y) - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    static function longint date_index(int unsigned y, int unsigned m, int unsigned d);
      longint n;
      n = year_start(y);
      for (int unsigned k = 1; k < m; k++) begin
        n += month_days(y, k);
      end
      return n + d - 1;
    endfunction

    static function logic [gdc_pkg::CODE_W-1:0] date_status(int unsigned y, int unsigned m,
                                                            int unsigned d);
      if (m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
        return gdc_pkg::STAT_INVALID;
      end
      if (y < 1 || y > gdc_pkg::MAX_YEAR) begin
        return gdc_pkg::STAT_RANGE;
      end
      return gdc_pkg::STAT_OK;
    endfunction

    function void index_to_date(longint n);
      int unsigned yy;
      longint rem;
      int unsigned mm;
      yy = 32'((n * 400) / 146097 + 1);
      if (yy > gdc_pkg::MAX_YEAR) begin
        yy = gdc_pkg::MAX_YEAR;
      end
      while (yy > 1 && year_start(yy) > n) yy--;
      while (yy < gdc_pkg::MAX_YEAR && year_start(yy + 1) <= n) yy++;
      rem = n - year_start(yy);
      mm = 1;
      while (mm < 12 && rem >= month_days(yy, mm)) begin
        rem -= month_days(yy, mm);
        mm++;
      end
      cur_y = yy;
      cur_m = mm;
      cur_d = 32'(rem + 1);
    endfunction

    function gdc_pkg::result_t step_date(gdc_pkg::item_t w);
      gdc_pkg::result_t r;
      logic [gdc_pkg::CODE_W-1:0] st;
      logic [gdc_pkg::CODE_W-1:0] ord;
      longint diff;
      longint n;
      st = gdc_pkg::STAT_OK;
      ord = gdc_pkg::ORD_EQUAL;
      diff = 0;
      case (w.func)
        gdc_pkg::FUNC_LOAD: begin
          st = date_status(w.year, w.month, w.day);
          if (st == gdc_pkg::STAT_OK) begin
            cur_y = w.year;
            cur_m = w.month;
            cur_d = w.day;
          end
        end
        gdc_pkg::FUNC_ADD: begin
          n = date_index(cur_y, cur_m, cur_d) + longint'(w.offset);
          if (n < 0 || n > longint'(gdc_pkg::LAST_DAY)) begin
            st = gdc_pkg::STAT_RANGE;
          end else begin
            index_to_date(n);
          end
        end
        gdc_pkg::FUNC_COMPARE: begin
          st = date_status(w.year, w.month, w.day);
          if (st == gdc_pkg::STAT_OK) begin
            diff = date_index(cur_y, cur_m, cur_d) - date_index(w.year, w.month, w.day);
            ord = (diff > 0) ? gdc_pkg::ORD_LATER :
                  ((diff < 0) ? gdc_pkg::ORD_EARLIER : gdc_pkg::ORD_EQUAL);
          end
        end
        default: ;
      endcase
      r.year = cur_y[gdc_pkg::YEAR_W-1:0];
      r.month = cur_m[gdc_pkg::MONTH_W-1:0];
      r.day = cur_d[gdc_pkg::DAY_W-1:0];
      r.status = st;
      r.order = ord;
      r.difference = diff[gdc_pkg::OFF_W-1:0];
      return r;
    endfunction

    function void note_request(gdc_pkg::item_t w);
      expected_q.push_back(step_date(w));
    endfunction

    function void match(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(gdc_pkg::result_t got);
      gdc_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("response word with no request pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      match("out_year", want.year, got.year);
      match("out_month", want.month, got.month);
      match("out_day", want.day, got.day);
      match("status", want.status, got.status);
      match("order", want.order, got.order);
      match("difference", want.difference, got.difference);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit calm;
  int unsigned quiet_cycles;
  date_tracker tracker;
  gdc_pkg::item_t directed_q[$];

  gdc_req_if req();
  gdc_rsp_if rsp();

  gregorian_date_calculator_top uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic gdc_pkg::item_t make_word(logic [gdc_pkg::FUNC_W-1:0] f,
                                               int unsigned y, int unsigned m,
                                               int unsigned d, int off);
    gdc_pkg::item_t w;
    w.func = f;
    w.year = y[gdc_pkg::YEAR_W-1:0];
    w.month = m[gdc_pkg::MONTH_W-1:0];
    w.day = d[gdc_pkg::DAY_W-1:0];
    w.offset = off[gdc_pkg::OFF_W-1:0];
    return w;
  endfunction

  function automatic void pick_date(output int unsigned y, output int unsigned m,
                                    output int unsigned d);
    case ($urandom_range(0, 9))
      0: y = $urandom_range(1, 4);
      1: y = $urandom_range(9996, 9999);
      2: y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, gdc_pkg::MAX_YEAR);
    endcase
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 4) == 0) ? date_tracker::month_days(y, m)
                                    : $urandom_range(1, date_tracker::month_days(y, m));
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(0, 8000000) - 4000000;
      3, 4: return int'({{9{1'b0}}, $urandom_range(0, 8388607)}) - 4194304;
      5, 6, 7, 8: return $urandom_range(0, 80000) - 40000;
      default: return $urandom_range(0, 800) - 400;
    endcase
  endfunction

  function automatic gdc_pkg::item_t random_word();
    gdc_pkg::item_t w;
    int unsigned y, m, d;
    int unsigned pick;
    w = make_word(gdc_pkg::FUNC_LOAD, 0, 0, 0, 0);
    w.year = gdc_pkg::YEAR_W'($urandom_range(0, 16383));
    w.month = gdc_pkg::MONTH_W'($urandom_range(0, 15));
    w.day = gdc_pkg::DAY_W'($urandom_range(0, 31));
    w.offset = gdc_pkg::OFF_W'($urandom_range(0, 8388607));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.func = gdc_pkg::FUNC_LOAD;
    end else if (pick < 60) begin
      w.func = gdc_pkg::FUNC_ADD;
      w.offset = gdc_pkg::OFF_W'(pick_offset());
    end else if (pick < 93) begin
      w.func = gdc_pkg::FUNC_COMPARE;
    end else begin
      w.func = gdc_pkg::FUNC_W'($urandom_range(0, 3));
      return w;
    end
    if (w.func != gdc_pkg::FUNC_ADD && $urandom_range(0, 99) >= 15) begin
      pick_date(y, m, d);
      w.year = y[gdc_pkg::YEAR_W-1:0];
      w.month = m[gdc_pkg::MONTH_W-1:0];
      w.day = d[gdc_pkg::DAY_W-1:0];
    end
    return w;
  endfunction

  task automatic send_word(input gdc_pkg::item_t w);
    while (!calm && $urandom_range(0, 99) < 24) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func <= w.func;
    req.in_year <= w.year;
    req.in_month <= w.month;
    req.in_day <= w.day;
    req.offset <= w.offset;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(w);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp.ready <= calm || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      gdc_pkg::result_t got;
      got.year = rsp.out_year;
      got.month = rsp.out_month;
      got.day = rsp.out_day;
      got.status = rsp.status;
      got.order = rsp.order;
      got.difference = rsp.difference;
      tracker.check_response(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    calm = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = gdc_pkg::FUNC_LOAD;
    req.in_year = '0;
    req.in_month = '0;
    req.in_day = '0;
    req.offset = '0;

    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 1, 1, 1, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, -1));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 9999, 12, 31, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, 1));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, -3652058));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, 3652058));
    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 1, 1, 1, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, 4194303));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 16383, 15, 31, -4194304));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 1900, 2, 29, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2000, 2, 29, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, 365));
    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 2024, 2, 29, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 2001, 2, 28, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2023, 0, 1, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2023, 13, 1, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 16383, 15, 31, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2023, 4, 31, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2023, 1, 0, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 0, 2, 29, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 10000, 1, 1, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 16383, 12, 31, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_COMPARE, 1900, 2, 29, 0));
    directed_q.push_back(make_word(FUNC_SPARE, 16383, 15, 31, 4194303));
    directed_q.push_back(make_word(gdc_pkg::FUNC_LOAD, 2023, 12, 31, 0));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, 1));
    directed_q.push_back(make_word(gdc_pkg::FUNC_ADD, 0, 0, 0, -366));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_q[i]) begin
      send_word(directed_q[i]);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 400 && i < 520);
      send_word(random_word());
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/gdc_pkg.sv
src/gdc_if.sv
src/gdc_core.sv
src/gregorian_date_calculator_top.sv
sim/tb.sv
